// ===== hdl/ultrasonic_three_sensor_ranging_core_defines.svh =====
// assertion macros for the ultrasonic ranging core
// expects clk and rst_n in the scope where a macro is used
`ifndef ULTRASONIC_THREE_SENSOR_RANGING_CORE_DEFINES_SVH
`define ULTRASONIC_THREE_SENSOR_RANGING_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UTSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define UTSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/utsr_pkg.sv =====
// shared constants, types and codes for the ultrasonic ranging core
// no dependencies
package utsr_pkg;

  localparam int unsigned SAMPLES_DEF = 3;
  localparam int unsigned SENSORS_DEF = 3;

  localparam int unsigned NUM_SENSORS = 3;
  localparam int unsigned ECHO_W      = 3;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned PRESC_W     = 8;
  localparam int unsigned SUM_W       = 18;
  localparam int unsigned DIST_W      = 16;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CNT_W-1:0]   TRIG_LEN_RST = 16'd50;
  localparam logic [PRESC_W-1:0] PRESC_RST    = 8'd8;
  localparam logic [GAIN_W-1:0]  GAIN_RST     = 16'd706;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_MEAS
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0]   trig_len;
    logic [PRESC_W-1:0] prescale;
    logic [GAIN_W-1:0]  gain;
  } cfg_t;

  // one tick's control result, plus the sum of a finished sensor
  typedef struct packed {
    logic [ECHO_W-1:0] trig;
    logic              done;
    logic              busy;
    logic              upd;
    logic [IDX_W-1:0]  sensor;
    logic [SUM_W-1:0]  sum;
  } ctrl_res_t;

  typedef struct packed {
    logic [ECHO_W-1:0] trig;
    logic              done;
    logic              busy;
  } out_res_t;

endpackage

// ===== hdl/utsr_in_if.sv =====
// input channel of the ranging core: one pin sample per transaction
// depends on utsr_pkg
interface utsr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         start_req;
  logic [utsr_pkg::ECHO_W-1:0]  echo_levels;

  modport source (output valid, output start_req, output echo_levels, input ready);
  modport sink   (input valid, input start_req, input echo_levels, output ready);
endinterface

// ===== hdl/utsr_out_if.sv =====
// result channel of the ranging core: trigger pins, distances and status
// depends on utsr_pkg
interface utsr_out_if;
  logic                         valid;
  logic                         ready;
  logic [utsr_pkg::ECHO_W-1:0]  trigger_lines;
  logic [utsr_pkg::DIST_W-1:0]  distance_left;
  logic [utsr_pkg::DIST_W-1:0]  distance_front;
  logic [utsr_pkg::DIST_W-1:0]  distance_right;
  logic                         done_res;
  logic                         busy_res;

  modport source (output valid, output trigger_lines, output distance_left,
                  output distance_front, output distance_right, output done_res,
                  output busy_res, input ready);
  modport sink   (input valid, input trigger_lines, input distance_left,
                  input distance_front, input distance_right, input done_res,
                  input busy_res, output ready);
endinterface

// ===== hdl/utsr_ctrl.sv =====
// scan sequencer: trigger, echo wait and echo timing per reading
// depends on utsr_pkg; registers one control result per accepted transaction
module utsr_ctrl #(
  parameter int unsigned SAMPLES = utsr_pkg::SAMPLES_DEF,
  parameter int unsigned SENSORS = utsr_pkg::SENSORS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        start_req,
  input  logic [utsr_pkg::ECHO_W-1:0] echo_levels,
  input  utsr_pkg::cfg_t              cfg,
  output utsr_pkg::ctrl_res_t         s1_r
);

  localparam logic [utsr_pkg::IDX_W-1:0] SAMPLES_C = utsr_pkg::IDX_W'(SAMPLES);
  localparam logic [utsr_pkg::IDX_W-1:0] SENSORS_C = utsr_pkg::IDX_W'(SENSORS);

  utsr_pkg::phase_t                 phase_r, phase_nxt;
  logic [utsr_pkg::IDX_W-1:0]       sensor_r, sensor_nxt;
  logic [utsr_pkg::IDX_W-1:0]       sample_r, sample_nxt;
  logic [utsr_pkg::CNT_W-1:0]       tick_r, tick_nxt;
  logic [utsr_pkg::PRESC_W-1:0]     presc_r, presc_nxt;
  logic [utsr_pkg::CNT_W-1:0]       echo_cnt_r, echo_cnt_nxt;
  logic [utsr_pkg::SUM_W-1:0]       sum_r, sum_nxt;

  logic [utsr_pkg::ECHO_W:0]        echo_ext;
  logic                             my_echo;
  logic [utsr_pkg::SUM_W-1:0]       fin_sum;
  logic [utsr_pkg::IDX_W-1:0]       sample_inc;
  logic [utsr_pkg::IDX_W-1:0]       sensor_inc;
  logic                             fin_upd;
  logic                             fin_done;
  utsr_pkg::ctrl_res_t              res;

  // sensor index three has no echo pin and reads low
  assign echo_ext   = {1'b0, echo_levels};
  assign my_echo    = echo_ext[sensor_r];
  assign fin_sum    = sum_r + utsr_pkg::SUM_W'(echo_cnt_r);
  assign sample_inc = sample_r + 1'b1;
  assign sensor_inc = sensor_r + 1'b1;

  always_comb begin : next_state
    phase_nxt    = phase_r;
    sensor_nxt   = sensor_r;
    sample_nxt   = sample_r;
    tick_nxt     = tick_r;
    presc_nxt    = presc_r;
    echo_cnt_nxt = echo_cnt_r;
    sum_nxt      = sum_r;
    fin_upd      = 1'b0;
    fin_done     = 1'b0;
    case (phase_r)
      utsr_pkg::PH_IDLE: begin
        if (start_req) begin
          sensor_nxt = '0;
          sample_nxt = '0;
          sum_nxt    = '0;
          phase_nxt  = utsr_pkg::PH_TRIG;
          tick_nxt   = '0;
        end
      end
      utsr_pkg::PH_TRIG: begin
        tick_nxt = tick_r + 1'b1;
        if (tick_nxt >= cfg.trig_len) begin
          phase_nxt = utsr_pkg::PH_WAIT;
        end
      end
      utsr_pkg::PH_WAIT: begin
        if (my_echo) begin
          phase_nxt    = utsr_pkg::PH_MEAS;
          echo_cnt_nxt = '0;
          presc_nxt    = '0;
        end
      end
      utsr_pkg::PH_MEAS: begin
        if (!my_echo) begin
          if (sample_inc >= SAMPLES_C) begin
            fin_upd    = 1'b1;
            sample_nxt = '0;
            sum_nxt    = '0;
            if (sensor_inc >= SENSORS_C) begin
              phase_nxt  = utsr_pkg::PH_IDLE;
              sensor_nxt = '0;
              fin_done   = 1'b1;
            end else begin
              sensor_nxt = sensor_inc;
              phase_nxt  = utsr_pkg::PH_TRIG;
              tick_nxt   = '0;
            end
          end else begin
            sample_nxt = sample_inc;
            sum_nxt    = fin_sum;
            phase_nxt  = utsr_pkg::PH_TRIG;
            tick_nxt   = '0;
          end
        end else begin
          presc_nxt = presc_r + 1'b1;
          if (presc_nxt >= cfg.prescale) begin
            presc_nxt    = '0;
            echo_cnt_nxt = echo_cnt_r + 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = utsr_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin : outputs
    res.trig   = '0;
    if (phase_nxt == utsr_pkg::PH_TRIG) begin
      res.trig = utsr_pkg::ECHO_W'(4'b0001 << sensor_nxt);
    end
    res.done   = fin_done;
    res.busy   = (phase_nxt != utsr_pkg::PH_IDLE);
    res.upd    = fin_upd;
    res.sensor = sensor_r;
    res.sum    = fin_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= utsr_pkg::PH_IDLE;
      sensor_r   <= '0;
      sample_r   <= '0;
      tick_r     <= '0;
      presc_r    <= '0;
      echo_cnt_r <= '0;
      sum_r      <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      sensor_r   <= sensor_nxt;
      sample_r   <= sample_nxt;
      tick_r     <= tick_nxt;
      presc_r    <= presc_nxt;
      echo_cnt_r <= echo_cnt_nxt;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_r <= res;
    end
  end

endmodule

// ===== hdl/utsr_scale.sv =====
// averaging and gain stages, distance store and result register
// depends on utsr_pkg; two registered stages after the sequencer
module utsr_scale #(
  parameter int unsigned SAMPLES = utsr_pkg::SAMPLES_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  ld2,
  input  logic                                                  ld3,
  input  utsr_pkg::ctrl_res_t                                   s1,
  input  logic [utsr_pkg::GAIN_W-1:0]                           gain,
  output utsr_pkg::out_res_t                                    res_r,
  output logic [utsr_pkg::NUM_SENSORS-1:0][utsr_pkg::DIST_W-1:0] dist_r
);

  // floor(sum / SAMPLES) as a multiply by a rounded-up reciprocal
  localparam int unsigned RECIP_SH = 19;
  localparam int unsigned RECIP_W  = RECIP_SH + 1;
  localparam int unsigned QPROD_W  = utsr_pkg::SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SH) + SAMPLES - 1) / SAMPLES);
  localparam int unsigned DPROD_W  = utsr_pkg::DIST_W + utsr_pkg::GAIN_W;

  logic [QPROD_W-1:0]               q_prod;
  logic [DPROD_W-1:0]               d_prod;

  utsr_pkg::out_res_t               s2_res_r;
  logic                             s2_upd_r;
  logic [utsr_pkg::IDX_W-1:0]       s2_sensor_r;
  logic [utsr_pkg::DIST_W-1:0]      s2_avg_r;

  assign q_prod = QPROD_W'(s1.sum) * QPROD_W'(RECIP);
  assign d_prod = DPROD_W'(s2_avg_r) * DPROD_W'(gain);

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_res_r.trig <= s1.trig;
      s2_res_r.done <= s1.done;
      s2_res_r.busy <= s1.busy;
      s2_upd_r      <= s1.upd;
      s2_sensor_r   <= s1.sensor;
      s2_avg_r      <= q_prod[RECIP_SH +: utsr_pkg::DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      res_r <= s2_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
    end else if (ld3 && s2_upd_r) begin
      for (int k = 0; k < utsr_pkg::NUM_SENSORS; k++) begin
        if (s2_sensor_r == utsr_pkg::IDX_W'(k)) begin
          dist_r[k] <= d_prod[utsr_pkg::GAIN_W +: utsr_pkg::DIST_W];
        end
      end
    end
  end

endmodule

// ===== hdl/ultrasonic_three_sensor_ranging_core.sv =====
// a transaction passes the sequencer register, then the averaging register, then the result register
// throughput: one transaction per cycle; each stage stalls only while its successor is full
// the echo timer, reading and sensor counters advance only on an accepted transaction
// reset (synchronous, rst_n low) sets the sequencer idle, all counters and distances to zero,
// the registers to trigger length 50, prescale 8, gain 706, and empties the pipeline
`include "ultrasonic_three_sensor_ranging_core_defines.svh"

module ultrasonic_three_sensor_ranging_core #(
  parameter int unsigned SAMPLES = utsr_pkg::SAMPLES_DEF,
  parameter int unsigned SENSORS = utsr_pkg::SENSORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  utsr_in_if.sink                         in_ch,
  utsr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [utsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [utsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  utsr_pkg::cfg_t                                                cfg_r;
  utsr_pkg::ctrl_res_t                                           s1_r;
  utsr_pkg::out_res_t                                            res_r;
  logic [utsr_pkg::NUM_SENSORS-1:0][utsr_pkg::DIST_W-1:0]        dist_r;

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic step, ld2, ld3;

  assign rdy3 = !v3_r || out_ch.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign step = in_ch.valid && rdy1;
  assign ld2  = v1_r && rdy2;
  assign ld3  = v2_r && rdy3;

  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_ch.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_len <= utsr_pkg::TRIG_LEN_RST;
      cfg_r.prescale <= utsr_pkg::PRESC_RST;
      cfg_r.gain     <= utsr_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        utsr_pkg::CFG_TRIG_LEN: cfg_r.trig_len <= cfg_wdata;
        utsr_pkg::CFG_PRESCALE: cfg_r.prescale <= cfg_wdata[utsr_pkg::PRESC_W-1:0];
        utsr_pkg::CFG_GAIN:     cfg_r.gain     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  utsr_ctrl #(
    .SAMPLES (SAMPLES),
    .SENSORS (SENSORS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .start_req   (in_ch.start_req),
    .echo_levels (in_ch.echo_levels),
    .cfg         (cfg_r),
    .s1_r        (s1_r)
  );

  utsr_scale #(
    .SAMPLES (SAMPLES)
  ) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .ld2    (ld2),
    .ld3    (ld3),
    .s1     (s1_r),
    .gain   (cfg_r.gain),
    .res_r  (res_r),
    .dist_r (dist_r)
  );

  assign out_ch.valid          = v3_r;
  assign out_ch.trigger_lines  = res_r.trig;
  assign out_ch.done_res       = res_r.done;
  assign out_ch.busy_res       = res_r.busy;
  assign out_ch.distance_left  = dist_r[0];
  assign out_ch.distance_front = dist_r[1];
  assign out_ch.distance_right = dist_r[2];

  // a finished scan leaves the sequencer idle on the same transaction
  `UTSR_ASSERT_IMPL(a_done_not_busy, v3_r && res_r.done, !res_r.busy, "done while busy")
  // at most one trigger line, and only during a scan
  `UTSR_ASSERT_IMPL(a_trig_onehot, v3_r, $onehot0(res_r.trig), "several trigger lines")
  `UTSR_ASSERT_IMPL(a_trig_busy, v3_r && (res_r.trig != '0), res_r.busy, "trigger while idle")
  // a stalled stage keeps its transaction
  `UTSR_ASSERT_NEXT(a_s1_hold, v1_r && !rdy2, v1_r, "stage one transaction lost")

endmodule
